// ===== src/led_matrix_scan_controller_assert.svh =====
// Assertion macros used by the LED matrix scan controller checker.
`ifndef LED_MATRIX_SCAN_CONTROLLER_ASSERT_SVH
`define LED_MATRIX_SCAN_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LMSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lmsc_pkg.sv =====
// Types and constants used by the LED matrix scan controller.
package lmsc_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SWAP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int RED_POS   = 0;
    localparam int GREEN_POS = 1;
    localparam int BLUE_POS  = 2;

    localparam logic [15:0] HOLD_TICKS_RESET = 16'd200;

    typedef enum logic [5:0] {
        PH_SETUP    = 6'b000001,
        PH_CLK_LOW  = 6'b000010,
        PH_CLK_HIGH = 6'b000100,
        PH_LAT_LOW  = 6'b001000,
        PH_LAT_HIGH = 6'b010000,
        PH_HOLD     = 6'b100000
    } lmsc_phase_t;

    typedef struct packed {
        logic [2:0] addr;
        logic       shift_clk;
        logic       lat;
        logic       blank;
        logic       load;
    } lmsc_pins_t;

endpackage

// ===== src/lmsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module lmsc_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/led_matrix_scan_controller.sv =====
// LED matrix scan controller: double-buffered frame store and panel pin sequencer.
// Each item yields one beat via the b and output registers; one per cycle unless stalled.
// Clock-low ticks read the top and bottom frame RAMs; output registers drive the pins.
// After reset a clearing pass zeroes the frame RAMs, during which in_stall is high;
// configuration writes are taken at any time.
module led_matrix_scan_controller #(
    parameter int COLUMNS      = 32,
    parameter int ROW_PAIRS    = 8,
    parameter int BUFFER_COUNT = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [15:0]                            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [1:0]                             op,
    input  logic [$clog2(2*ROW_PAIRS*COLUMNS)-1:0] pixel_index,
    input  logic [7:0]                             red,
    input  logic [7:0]                             green,
    input  logic [7:0]                             blue,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [2:0]                             row_address,
    output logic                                   red_top,
    output logic                                   green_top,
    output logic                                   blue_top,
    output logic                                   red_bottom,
    output logic                                   green_bottom,
    output logic                                   blue_bottom,
    output logic                                   shift_clock,
    output logic                                   latch,
    output logic                                   blank
);

    localparam int HALF_PIXELS  = COLUMNS * ROW_PAIRS;
    localparam int FRAME_PIXELS = 2 * HALF_PIXELS;
    localparam int DEPTH        = BUFFER_COUNT * HALF_PIXELS;
    localparam int AW           = $clog2(DEPTH);
    localparam int PIX_W        = $clog2(FRAME_PIXELS);
    localparam int ROW_W        = $clog2(ROW_PAIRS);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int FS_W         = $clog2(BUFFER_COUNT);

    logic                     clr_active_reg;
    logic [AW-1:0]            clr_addr_reg;
    logic [15:0]              hold_ticks_reg;
    logic [FS_W-1:0]          front_reg, front_next;
    lmsc_pkg::lmsc_phase_t    phase_reg, phase_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic [15:0]              hold_reg, hold_next;
    logic [2:0]               addr_reg, addr_next;
    logic                     clk_pin_reg, clk_pin_next;
    logic                     lat_reg, lat_next;
    logic                     blank_reg, blank_next;
    logic                     b_valid_reg;
    lmsc_pkg::lmsc_pins_t     b_pins_reg, b_pins_next;
    logic [2:0]               top_reg, bottom_reg;
    logic                     out_valid_reg;
    logic [2:0]               out_addr_reg;
    logic [2:0]               out_top_reg, out_bottom_reg;
    logic                     out_clk_reg, out_lat_reg, out_blank_reg;

    logic                     accept;
    logic                     b_adv;
    logic                     is_write, is_tick, in_range, wr_bottom;
    logic [2:0]               color;
    logic [FS_W-1:0]          back_sel;
    logic [PIX_W-1:0]         local_idx;
    logic [AW-1:0]            wr_addr_item, rd_addr;
    logic                     rd_en;
    logic                     top_wr_en, bottom_wr_en;
    logic [AW-1:0]            wr_addr;
    logic [2:0]               wr_data;
    logic [2:0]               top_rd, bottom_rd;
    logic [15:0]              hold_dec;
    logic [2:0]               top_now, bottom_now;

    assign cfg_ready = 1'b1;
    assign b_adv     = !out_valid_reg || !out_stall;
    assign in_stall  = clr_active_reg || (b_valid_reg && !b_adv);
    assign accept    = in_valid && !in_stall;

    assign is_write = accept && (op == lmsc_pkg::OP_WRITE);
    assign is_tick  = accept && (op == lmsc_pkg::OP_TICK);
    assign in_range = {1'b0, pixel_index} < (PIX_W + 1)'(FRAME_PIXELS);
    assign wr_bottom = {1'b0, pixel_index} >= (PIX_W + 1)'(HALF_PIXELS);
    assign local_idx = wr_bottom ? pixel_index - PIX_W'(HALF_PIXELS) : pixel_index;
    assign back_sel  = (front_reg == FS_W'(BUFFER_COUNT - 1)) ? '0 : front_reg + 1'b1;

    always_comb
    begin
        color = '0;
        color[lmsc_pkg::RED_POS]   = (red != 8'd0);
        color[lmsc_pkg::GREEN_POS] = (green != 8'd0);
        color[lmsc_pkg::BLUE_POS]  = (blue != 8'd0);
    end

    assign wr_addr_item = AW'(back_sel) * AW'(HALF_PIXELS) + AW'(local_idx);
    assign rd_addr      = AW'(front_reg) * AW'(HALF_PIXELS)
                        + AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign rd_en        = is_tick && (phase_reg == lmsc_pkg::PH_CLK_LOW);

    assign top_wr_en    = clr_active_reg || (is_write && in_range && !wr_bottom);
    assign bottom_wr_en = clr_active_reg || (is_write && in_range && wr_bottom);
    assign wr_addr      = clr_active_reg ? clr_addr_reg : wr_addr_item;
    assign wr_data      = clr_active_reg ? 3'b000 : color;

    lmsc_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_top_ram (
        .clk     (clk),
        .wr_en   (top_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top_rd)
    );

    lmsc_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_bottom_ram (
        .clk     (clk),
        .wr_en   (bottom_wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (bottom_rd)
    );

    assign hold_dec = (hold_reg != 16'd0) ? hold_reg - 16'd1 : 16'd0;

    always_comb
    begin
        front_next   = front_reg;
        phase_next   = phase_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        hold_next    = hold_reg;
        addr_next    = addr_reg;
        clk_pin_next = clk_pin_reg;
        lat_next     = lat_reg;
        blank_next   = blank_reg;
        if (accept && (op == lmsc_pkg::OP_SWAP))
        begin
            front_next = back_sel;
        end
        if (is_tick)
        begin
            case (phase_reg)
                lmsc_pkg::PH_SETUP:
                begin
                    addr_next  = 3'(row_reg);
                    blank_next = 1'b1;
                    col_next   = '0;
                    phase_next = lmsc_pkg::PH_CLK_LOW;
                end
                lmsc_pkg::PH_CLK_LOW:
                begin
                    clk_pin_next = 1'b0;
                    phase_next   = lmsc_pkg::PH_CLK_HIGH;
                end
                lmsc_pkg::PH_CLK_HIGH:
                begin
                    clk_pin_next = 1'b1;
                    if (col_reg == COL_W'(COLUMNS - 1))
                    begin
                        col_next   = '0;
                        phase_next = lmsc_pkg::PH_LAT_LOW;
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        phase_next = lmsc_pkg::PH_CLK_LOW;
                    end
                end
                lmsc_pkg::PH_LAT_LOW:
                begin
                    lat_next   = 1'b0;
                    phase_next = lmsc_pkg::PH_LAT_HIGH;
                end
                lmsc_pkg::PH_LAT_HIGH:
                begin
                    lat_next   = 1'b1;
                    blank_next = 1'b0;
                    hold_next  = hold_ticks_reg;
                    if (hold_ticks_reg == 16'd0)
                    begin
                        row_next   = (row_reg == ROW_W'(ROW_PAIRS - 1)) ? '0 : row_reg + 1'b1;
                        phase_next = lmsc_pkg::PH_SETUP;
                    end
                    else
                    begin
                        phase_next = lmsc_pkg::PH_HOLD;
                    end
                end
                lmsc_pkg::PH_HOLD:
                begin
                    hold_next = hold_dec;
                    if (hold_dec == 16'd0)
                    begin
                        row_next   = (row_reg == ROW_W'(ROW_PAIRS - 1)) ? '0 : row_reg + 1'b1;
                        phase_next = lmsc_pkg::PH_SETUP;
                    end
                end
                default:
                begin
                    phase_next = lmsc_pkg::PH_SETUP;
                end
            endcase
        end
    end

    always_comb
    begin
        b_pins_next.addr      = addr_next;
        b_pins_next.shift_clk = clk_pin_next;
        b_pins_next.lat       = lat_next;
        b_pins_next.blank     = blank_next;
        b_pins_next.load      = rd_en;
    end

    assign top_now    = b_pins_reg.load ? top_rd : top_reg;
    assign bottom_now = b_pins_reg.load ? bottom_rd : bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            hold_ticks_reg <= lmsc_pkg::HOLD_TICKS_RESET;
            front_reg      <= '0;
            phase_reg      <= lmsc_pkg::PH_SETUP;
            row_reg        <= '0;
            col_reg        <= '0;
            hold_reg       <= '0;
            addr_reg       <= '0;
            clk_pin_reg    <= 1'b0;
            lat_reg        <= 1'b1;
            blank_reg      <= 1'b1;
            b_valid_reg    <= 1'b0;
            top_reg        <= '0;
            bottom_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                hold_ticks_reg <= cfg_data;
            end
            front_reg   <= front_next;
            phase_reg   <= phase_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            hold_reg    <= hold_next;
            addr_reg    <= addr_next;
            clk_pin_reg <= clk_pin_next;
            lat_reg     <= lat_next;
            blank_reg   <= blank_next;
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_valid_reg && b_adv)
            begin
                top_reg       <= top_now;
                bottom_reg    <= bottom_now;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_pins_reg <= b_pins_next;
        end
        if (b_valid_reg && b_adv)
        begin
            out_addr_reg   <= b_pins_reg.addr;
            out_top_reg    <= top_now;
            out_bottom_reg <= bottom_now;
            out_clk_reg    <= b_pins_reg.shift_clk;
            out_lat_reg    <= b_pins_reg.lat;
            out_blank_reg  <= b_pins_reg.blank;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_address  = out_addr_reg;
    assign red_top      = out_top_reg[lmsc_pkg::RED_POS];
    assign green_top    = out_top_reg[lmsc_pkg::GREEN_POS];
    assign blue_top     = out_top_reg[lmsc_pkg::BLUE_POS];
    assign red_bottom   = out_bottom_reg[lmsc_pkg::RED_POS];
    assign green_bottom = out_bottom_reg[lmsc_pkg::GREEN_POS];
    assign blue_bottom  = out_bottom_reg[lmsc_pkg::BLUE_POS];
    assign shift_clock  = out_clk_reg;
    assign latch        = out_lat_reg;
    assign blank        = out_blank_reg;

endmodule

// ===== src/lmsc_checker.sv =====
// Port-level checker for the LED matrix scan controller and its bind statement.
`include "led_matrix_scan_controller_assert.svh"

module lmsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  row_address,
    input logic        shift_clock,
    input logic        latch,
    input logic        blank
);

    // A stalled beat stays offered.
    `LMSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat was dropped")

    // A stalled beat keeps its pin levels.
    `LMSC_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(row_address) && $stable(shift_clock) && $stable(latch) && $stable(blank),
        "stalled beat changed")

    // The latch pulse only happens while the display is blanked.
    `LMSC_ASSERT_NOW(a_latch_blanked, out_valid && !latch, blank,
        "latch low while display is lit")

    // While the display is lit the latch line rests high.
    `LMSC_ASSERT_NOW(a_lit_latch_high, out_valid && !blank, latch,
        "display lit with latch low")

endmodule

bind led_matrix_scan_controller lmsc_checker u_lmsc_checker (.*);
